/* src/dssr_pkg.sv */
// ----------------------------------------------------------------------------
// dssr_pkg
// Shared constants and helpers for the disc and square span rasterizer:
// register indexes, reset values, datapath widths and the byte swap.
// ----------------------------------------------------------------------------
package dssr_pkg;

  // register indexes on the config port
  localparam logic [2:0] REG_VIEW_OFFSET_X   = 3'd0;
  localparam logic [2:0] REG_VIEW_OFFSET_Y   = 3'd1;
  localparam logic [2:0] REG_ZOOM_FACTOR     = 3'd2;
  localparam logic [2:0] REG_SCREEN_WIDTH    = 3'd3;
  localparam logic [2:0] REG_SCREEN_HEIGHT   = 3'd4;
  localparam logic [2:0] REG_ROW_PITCH_BYTES = 3'd5;
  localparam logic [2:0] REG_BYTE_ORDER      = 3'd6;

  // reset values
  localparam logic [15:0] RST_ZOOM_FACTOR     = 16'd256;
  localparam logic [12:0] RST_SCREEN_WIDTH    = 13'd640;
  localparam logic [12:0] RST_SCREEN_HEIGHT   = 13'd480;
  localparam logic [14:0] RST_ROW_PITCH_BYTES = 15'd2560;

  localparam int DEF_MAX_RADIUS = 32;

  // signed screen coordinate width, covers scaled world coords plus half screen
  localparam int CW = 27;

  // shared multiplier operand widths
  localparam int MUL_AW = 17;
  localparam int MUL_BW = 16;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // color as stored in memory for the chosen byte order
  function automatic logic [31:0] order_color(input logic swap, input logic [31:0] c);
    logic [31:0] w;
    w = swap ? {c[7:0], c[15:8], c[23:16], c[31:24]} : c;
    return w;
  endfunction

  // magnitude of a 17-bit signed sum, 65536 fits as unsigned
  function automatic logic [MUL_AW-1:0] mag17(input logic signed [MUL_AW-1:0] v);
    logic [MUL_AW-1:0] m;
    m = v[MUL_AW-1] ? MUL_AW'(-v) : MUL_AW'(v);
    return m;
  endfunction

endpackage

/* src/disc_and_square_span_rasterizer.sv */
// ----------------------------------------------------------------------------
// disc_and_square_span_rasterizer
// Turns one draw command (filled disc or filled square) into row spans,
// top row first, each clipped to the screen with its framebuffer address.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | word
//  ---------+------------------------+-----------------------------------------
//  command  | in_valid / in_ready    | mode, center_x, center_y, extent, color
//  span     | out_valid / out_ready  | row_index, byte_address, first_column,
//           |                        | pixel_count, pixel_word, last
//  config   | cfg_we (no wait)       | cfg_index, cfg_data
//
// after a command is taken: setup states MX, MY, ME, H, HH and HQ; then for each
// row a row test, which alone handles a row off screen; a square row goes on to
// SPAN and ADDR, a disc row to SQI, the bit-pair square root loop, SPAN and ADDR
// (a row clipped empty skips the address step); then the end test and flush step
// all multiplies go through one 17x16 multiplier with a registered product
// reset is synchronous and active high; config comes back to its reset values
// a span is held one row back so last can be marked; a stalled span output
// holds the sequencer at the address or flush step, in_ready is high only when idle
//
module disc_and_square_span_rasterizer
  import dssr_pkg::*;
#(
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic               clk,
  input  logic               rst,
  // config write port
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // command channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic signed [15:0] center_x,
  input  logic signed [15:0] center_y,
  input  logic [15:0]        extent,
  input  logic [31:0]        color,
  // span channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [11:0]        row_index,
  output logic [25:0]        byte_address,
  output logic [11:0]        first_column,
  output logic [6:0]         pixel_count,
  output logic [31:0]        pixel_word,
  output logic               last
);

  // radius width, squared-radius width and first square root trial bit
  localparam int HW = $clog2(MAX_RADIUS + 1);
  localparam int VW = 2 * HW;
  localparam logic [VW-1:0] SQ_START = VW'(1) << (VW - 2);
  localparam logic [23:0] MAX_R24 = 24'(MAX_RADIUS);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MX    = 4'd1;   // multiply x sum by zoom
  localparam logic [3:0] S_MY    = 4'd2;   // take cx, multiply y sum
  localparam logic [3:0] S_ME    = 4'd3;   // take cy, multiply extent
  localparam logic [3:0] S_H     = 4'd4;   // saturate the radius or half extent
  localparam logic [3:0] S_HH    = 4'd5;   // square h, set the first row
  localparam logic [3:0] S_HQ    = 4'd6;   // keep h*h
  localparam logic [3:0] S_ROW   = 4'd7;   // row test, square dy
  localparam logic [3:0] S_SQI   = 4'd8;   // root setup
  localparam logic [3:0] S_SQ    = 4'd9;   // one root bit pair per cycle
  localparam logic [3:0] S_SPAN  = 4'd10;  // columns, clip, row*pitch
  localparam logic [3:0] S_ADDR  = 4'd11;  // address, hand span on
  localparam logic [3:0] S_FLUSH = 4'd12;  // final span with last

  logic [3:0] state;

  // configuration
  logic signed [15:0] off_x, off_y;
  logic [15:0]        zoom;
  logic [12:0]        scr_w, scr_h;
  logic [14:0]        pitch;
  logic               swap_bytes;

  // command
  logic                     mode_q;
  logic signed [MUL_AW-1:0] sum_x, sum_y;
  logic [15:0]              ext_q;
  logic [31:0]              word_q;

  // geometry
  logic signed [CW-1:0] cx, cy, row;
  logic [HW-1:0]        h;
  logic [VW-1:0]        hh;

  // shared multiplier
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] mul_q;
  logic              mul_ld;

  // square root
  logic [VW-1:0] v, res, sq_bit;
  logic [VW:0]   trial;

  // current span
  logic [12:0] lo_q;
  logic [6:0]  cnt_q;

  // span held back one row
  logic        pend_valid;
  logic [11:0] pend_row;
  logic [25:0] pend_addr;
  logic [11:0] pend_col;
  logic [6:0]  pend_cnt;

  // combinational helpers
  logic [24:0]          q_mag;
  logic signed [CW-1:0] q_pos, q_coord;
  logic signed [CW-1:0] half_w, half_h, h_ext, s_ext, row_end, dy, dy_abs;
  logic                 row_vis;
  logic [23:0]          scaled, half_sc;
  logic [HW-1:0]        h_sat;
  logic signed [CW-1:0] w_last, lo_raw, hi_raw, hi_disc, lo_c, hi_c, span_len;
  logic                 span_empty;
  logic [25:0]          new_addr;
  logic                 out_free;
  logic                 out_load;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  // held span moves into the output register
  assign out_load = pend_valid && out_free && (state == S_ADDR || state == S_FLUSH);

  // scaled coordinate: sign of the world sum applied to the truncated magnitude
  assign q_mag   = mul_q[32:8];
  assign q_pos   = $signed({2'b00, q_mag});
  assign half_w  = $signed({{(CW-12){1'b0}}, scr_w[12:1]});
  assign half_h  = $signed({{(CW-12){1'b0}}, scr_h[12:1]});
  always_comb begin
    if (state == S_MY) begin
      q_coord = sum_x[MUL_AW-1] ? -q_pos : q_pos;
    end else begin
      q_coord = sum_y[MUL_AW-1] ? -q_pos : q_pos;
    end
  end

  // radius (disc) or half extent (square), saturated at the radius bound
  assign scaled  = mul_q[31:8];
  assign half_sc = {1'b0, scaled[23:1]};
  always_comb begin
    if (!mode_q) begin
      h_sat = (scaled > MAX_R24) ? HW'(MAX_RADIUS) : scaled[HW-1:0];
    end else begin
      h_sat = (half_sc > MAX_R24) ? HW'(MAX_RADIUS) : half_sc[HW-1:0];
    end
  end

  assign h_ext   = $signed({{(CW-HW){1'b0}}, h});
  assign s_ext   = $signed({{(CW-VW){1'b0}}, res});
  assign row_end = cy + h_ext;
  assign dy      = row - cy;
  assign dy_abs  = dy[CW-1] ? -dy : dy;
  assign row_vis = !row[CW-1] && (row < $signed({{(CW-13){1'b0}}, scr_h}));

  assign trial = {1'b0, res} + {1'b0, sq_bit};

  // span columns and screen clip
  assign w_last  = $signed({{(CW-13){1'b0}}, scr_w}) - CW'(1);
  assign hi_disc = ((cx + s_ext) > (cx + h_ext - CW'(1))) ? (cx + h_ext - CW'(1))
                                                          : (cx + s_ext);
  assign lo_raw  = mode_q ? (cx - h_ext) : (cx - s_ext);
  assign hi_raw  = mode_q ? (cx + h_ext - CW'(1)) : hi_disc;
  assign lo_c    = lo_raw[CW-1] ? '0 : lo_raw;
  assign hi_c    = (hi_raw > w_last) ? w_last : hi_raw;
  assign span_empty = (lo_c > hi_c);
  assign span_len   = hi_c - lo_c + CW'(1);

  assign new_addr = mul_q[25:0] + {11'b0, lo_q, 2'b00};

  // multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_ld = 1'b1;
    case (state)
      S_MX:    begin mul_a = mag17(sum_x);        mul_b = zoom; end
      S_MY:    begin mul_a = mag17(sum_y);        mul_b = zoom; end
      S_ME:    begin mul_a = {1'b0, ext_q};       mul_b = zoom; end
      S_HH:    begin mul_a = MUL_AW'(h);          mul_b = MUL_BW'(h); end
      S_ROW:   begin
        mul_a = MUL_AW'(dy_abs[HW-1:0]);
        mul_b = MUL_BW'(dy_abs[HW-1:0]);
      end
      S_SPAN:  begin mul_a = {4'b0, row[12:0]};   mul_b = {1'b0, pitch}; end
      default: mul_ld = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_ld) begin
      mul_q <= mul_a * mul_b;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      off_x      <= '0;
      off_y      <= '0;
      zoom       <= RST_ZOOM_FACTOR;
      scr_w      <= RST_SCREEN_WIDTH;
      scr_h      <= RST_SCREEN_HEIGHT;
      pitch      <= RST_ROW_PITCH_BYTES;
      swap_bytes <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VIEW_OFFSET_X:   off_x      <= $signed(cfg_data);
        REG_VIEW_OFFSET_Y:   off_y      <= $signed(cfg_data);
        REG_ZOOM_FACTOR:     zoom       <= cfg_data;
        REG_SCREEN_WIDTH:    scr_w      <= cfg_data[12:0];
        REG_SCREEN_HEIGHT:   scr_h      <= cfg_data[12:0];
        REG_ROW_PITCH_BYTES: pitch      <= cfg_data[14:0];
        REG_BYTE_ORDER:      swap_bytes <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // output valid: set on a load, cleared when the consumer drains it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode_q <= mode;
            sum_x  <= MUL_AW'(off_x) + MUL_AW'(center_x);
            sum_y  <= MUL_AW'(off_y) + MUL_AW'(center_y);
            ext_q  <= extent;
            word_q <= order_color(swap_bytes, color);
            state  <= S_MX;
          end
        end
        S_MX: state <= S_MY;
        S_MY: begin
          cx    <= q_coord + half_w;
          state <= S_ME;
        end
        S_ME: begin
          cy    <= q_coord + half_h;
          state <= S_H;
        end
        S_H: begin
          h     <= h_sat;
          state <= S_HH;
        end
        S_HH: begin
          row   <= cy - h_ext;
          state <= S_HQ;
        end
        S_HQ: begin
          hh    <= mul_q[VW-1:0];
          state <= S_ROW;
        end
        S_ROW: begin
          if (row >= row_end) begin
            state <= S_FLUSH;
          end else if (!row_vis) begin
            row <= row + CW'(1);
          end else if (mode_q) begin
            state <= S_SPAN;
          end else begin
            state <= S_SQI;
          end
        end
        S_SQI: begin
          // dy*dy never exceeds h*h inside the row range
          v      <= hh - mul_q[VW-1:0];
          res    <= '0;
          sq_bit <= SQ_START;
          state  <= S_SQ;
        end
        S_SQ: begin
          if ({1'b0, v} >= trial) begin
            v   <= v - trial[VW-1:0];
            res <= (res >> 1) + sq_bit;
          end else begin
            res <= res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          if (sq_bit == VW'(1)) begin
            state <= S_SPAN;
          end
        end
        S_SPAN: begin
          if (span_empty) begin
            row   <= row + CW'(1);
            state <= S_ROW;
          end else begin
            lo_q  <= lo_c[12:0];
            cnt_q <= span_len[6:0];
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              row_index    <= pend_row;
              byte_address <= pend_addr;
              first_column <= pend_col;
              pixel_count  <= pend_cnt;
              pixel_word   <= word_q;
              last         <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_row   <= row[11:0];
            pend_addr  <= new_addr;
            pend_col   <= lo_q[11:0];
            pend_cnt   <= cnt_q;
            row        <= row + CW'(1);
            state      <= S_ROW;
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            row_index    <= pend_row;
            byte_address <= pend_addr;
            first_column <= pend_col;
            pixel_count  <= pend_cnt;
            pixel_word   <= word_q;
            last         <= 1'b1;
            pend_valid   <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // no span may be left behind once a command is done
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("held span left over at idle");

  // flushing the final span ends the command and marks it last
  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && pend_valid && out_free) |=> (state == S_IDLE && out_valid && last))
    else $error("final span not marked last");

  // a span covers at least one and at most a full diameter of pixels
  a_span_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pixel_count != 7'd0 && pixel_count <= 7'(2 * MAX_RADIUS)))
    else $error("span pixel count out of range");

  // the root of h*h - dy*dy never exceeds h
  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SPAN && !mode_q) |-> (res <= VW'(h)))
    else $error("square root above radius");

endmodule

/* verif/disc_and_square_span_rasterizer_tb.sv */
// ----------------------------------------------------------------------------
// disc_and_square_span_rasterizer_tb
// Self-checking bench for the span rasterizer: draw commands go in over a
// valid/ready channel, every span word coming out is checked against a
// behavioral span predictor across several view, zoom and screen settings.
// ----------------------------------------------------------------------------
module disc_and_square_span_rasterizer_tb
  import dssr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // shape kinds and byte orders
  localparam logic MODE_DISC        = 1'b0;
  localparam logic MODE_SQUARE      = 1'b1;
  localparam logic ORDER_LOW_FIRST  = 1'b0;
  localparam logic ORDER_HIGH_FIRST = 1'b1;

  // wait after the last expected span, covers a full disc plus a stalled drain
  localparam int DRAIN_CYCLES  = 800;
  localparam int STUCK_LIMIT   = 20000;

  typedef struct packed {
    logic        mode;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] ext;
    logic [31:0] color;
  } draw_cmd_t;

  typedef struct packed {
    logic [11:0] row_index;
    logic [25:0] byte_address;
    logic [11:0] first_column;
    logic [6:0]  pixel_count;
    logic [31:0] pixel_word;
    logic        last;
  } span_t;

  // --------------------------------------------------------------------------
  // span predictor and store of spans still due
  // --------------------------------------------------------------------------
  class span_scoreboard;
    logic [15:0] off_x, off_y, zoom;
    logic [12:0] scr_w, scr_h;
    logic [14:0] pitch;
    logic        swap;
    span_t       spans_due[$];
    int          errors;

    function new();
      off_x  = '0;
      off_y  = '0;
      zoom   = RST_ZOOM_FACTOR;
      scr_w  = RST_SCREEN_WIDTH;
      scr_h  = RST_SCREEN_HEIGHT;
      pitch  = RST_ROW_PITCH_BYTES;
      swap   = ORDER_LOW_FIRST;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] d);
      case (idx)
        REG_VIEW_OFFSET_X:   off_x = d;
        REG_VIEW_OFFSET_Y:   off_y = d;
        REG_ZOOM_FACTOR:     zoom  = d;
        REG_SCREEN_WIDTH:    scr_w = d[12:0];
        REG_SCREEN_HEIGHT:   scr_h = d[12:0];
        REG_ROW_PITCH_BYTES: pitch = d[14:0];
        REG_BYTE_ORDER:      swap  = d[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return spans_due.size();
    endfunction

    // q8.8 zoom of a world coordinate, truncated toward zero
    function longint zoomed(logic [15:0] off, logic [15:0] pos);
      longint s, mag, q;
      s   = longint'($signed(off)) + longint'($signed(pos));
      mag = (s < 0) ? -s : s;
      q   = (mag * longint'(zoom)) >> 8;
      return (s < 0) ? -q : q;
    endfunction

    function longint root_floor(longint v);
      longint r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
    endfunction

    function void take_command(draw_cmd_t c);
      longint cx, cy, scaled, h, row, dy, s, lo, hi;
      logic [31:0] word;
      span_t held;
      bit have;
      have   = 0;
      cx     = zoomed(off_x, c.cx) + longint'(scr_w / 2);
      cy     = zoomed(off_y, c.cy) + longint'(scr_h / 2);
      scaled = (longint'(c.ext) * longint'(zoom)) >> 8;
      if (c.mode == MODE_DISC) h = scaled;
      else h = scaled / 2;
      if (h > DEF_MAX_RADIUS) h = DEF_MAX_RADIUS;
      word = swap ? {c.color[7:0], c.color[15:8], c.color[23:16], c.color[31:24]}
                  : c.color;
      for (row = cy - h; row < cy + h; row++) begin
        if (row < 0 || row >= longint'(scr_h)) continue;
        if (c.mode == MODE_DISC) begin
          dy = row - cy;
          s  = root_floor(h * h - dy * dy);
          lo = cx - s;
          hi = cx + s;
          if (hi > cx + h - 1) hi = cx + h - 1;
        end else begin
          lo = cx - h;
          hi = cx + h - 1;
        end
        if (lo < 0) lo = 0;
        if (hi > longint'(scr_w) - 1) hi = longint'(scr_w) - 1;
        if (lo > hi) continue;
        // hold one back so the final span of the command can be marked
        if (have) spans_due.push_back(held);
        held.row_index    = 12'(row);
        held.byte_address = 26'(row * longint'(pitch) + lo * 4);
        held.first_column = 12'(lo);
        held.pixel_count  = 7'(hi - lo + 1);
        held.pixel_word   = word;
        held.last         = 1'b0;
        have = 1;
      end
      if (have) begin
        held.last = 1'b1;
        spans_due.push_back(held);
      end
    endfunction

    function void cmp(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
        errors++;
        $display("%0t: span %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, e, a);
      end
    endfunction

    function void check_span(span_t a);
      span_t e;
      if (spans_due.size() == 0) begin
        errors++;
        $display("%0t: span word with none expected, actual row %0d col %0d count %0d",
                 $time, a.row_index, a.first_column, a.pixel_count);
        return;
      end
      e = spans_due.pop_front();
      cmp("row_index", e.row_index, a.row_index);
      cmp("byte_address", e.byte_address, a.byte_address);
      cmp("first_column", e.first_column, a.first_column);
      cmp("pixel_count", e.pixel_count, a.pixel_count);
      cmp("pixel_word", e.pixel_word, a.pixel_word);
      cmp("last", e.last, a.last);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block signals, every driven input known from time zero
  // --------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               mode = MODE_DISC;
  logic signed [15:0] center_x = '0;
  logic signed [15:0] center_y = '0;
  logic [15:0]        extent = '0;
  logic [31:0]        color = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [11:0]        row_index;
  logic [25:0]        byte_address;
  logic [11:0]        first_column;
  logic [6:0]         pixel_count;
  logic [31:0]        pixel_word;
  logic               last;

  span_scoreboard sb = new();

  // percent chance per cycle that a side holds off
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stuck_cycles = 0;

  always #1 clk = ~clk;

  disc_and_square_span_rasterizer u_top (.*);

  // receiver side: ready drops at random, independent of out_valid
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watch both channels; values read here are the ones sampled at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        sb.take_command({mode, center_x, center_y, extent, color});
      if (out_valid && out_ready)
        sb.check_span({row_index, byte_address, first_column, pixel_count,
                       pixel_word, last});
      // watchdog on cycles where neither channel moves a word
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic draw_cmd_t mk(logic m, logic [15:0] x, logic [15:0] y,
                                   logic [15:0] e, logic [31:0] col);
    draw_cmd_t c;
    c.mode  = m;
    c.cx    = x;
    c.cy    = y;
    c.ext   = e;
    c.color = col;
    return c;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  // mostly shapes that land around the visible area, some anywhere at all
  function automatic draw_cmd_t rand_cmd();
    draw_cmd_t c;
    longint z, reach, ext_cap;
    int sel;
    z       = (sb.zoom == 0) ? 1 : longint'(sb.zoom);
    reach   = ((longint'(sb.scr_w / 2) + 40) * 256) / z;
    ext_cap = (80 * 256) / z;
    if (reach > 65535) reach = 65535;
    if (ext_cap > 65535) ext_cap = 65535;
    if (ext_cap < 2) ext_cap = 2;
    sel     = $urandom_range(99);
    c.mode  = $urandom_range(1);
    c.color = $urandom;
    if (sel < 80) begin
      c.cx = clamp16(-longint'($signed(sb.off_x)) + longint'($urandom_range(2 * reach))
                     - reach);
      reach = ((longint'(sb.scr_h / 2) + 40) * 256) / z;
      if (reach > 65535) reach = 65535;
      c.cy = clamp16(-longint'($signed(sb.off_y)) + longint'($urandom_range(2 * reach))
                     - reach);
      c.ext = (sel < 70) ? 16'($urandom_range(ext_cap)) : 16'($urandom);
    end else begin
      c.cx  = 16'($urandom);
      c.cy  = 16'($urandom);
      c.ext = 16'($urandom);
    end
    return c;
  endfunction

  // present one command, then hold it until the block takes it
  task automatic send_cmd(draw_cmd_t c);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= c.mode;
    center_x <= c.cx;
    center_y <= c.cy;
    extent   <= c.ext;
    color    <= c.color;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_cmd(rand_cmd());
  endtask

  // drop valid, wait out every expected span, then let a command that
  // produced nothing finish its row walk too
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    sb.set_reg(idx, d);
    @(posedge clk);
  endtask

  task automatic apply_view(logic [15:0] ox, logic [15:0] oy, logic [15:0] z,
                            logic [15:0] w, logic [15:0] h, logic [15:0] p,
                            logic order);
    write_reg(REG_VIEW_OFFSET_X, ox);
    write_reg(REG_VIEW_OFFSET_Y, oy);
    write_reg(REG_ZOOM_FACTOR, z);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    write_reg(REG_ROW_PITCH_BYTES, p);
    write_reg(REG_BYTE_ORDER, {15'd0, order});
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed shapes at reset view: 640x480, center lands on (320, 240)
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_cmd(mk(MODE_DISC, 0, 0, 0, 32'h0000_0000));        // zero extent disc
    send_cmd(mk(MODE_SQUARE, 0, 0, 0, 32'hffff_ffff));      // zero extent square
    send_cmd(mk(MODE_SQUARE, 0, 0, 1, 32'h1234_5678));      // half side rounds to 0
    send_cmd(mk(MODE_DISC, 0, 0, 1, 32'h89ab_cdef));        // smallest disc
    send_cmd(mk(MODE_DISC, 0, 0, 32, 32'ha5a5_5a5a));       // radius right at the cap
    send_cmd(mk(MODE_DISC, 5, -7, 16'hffff, 32'h5a5a_a5a5)); // radius saturates
    send_cmd(mk(MODE_SQUARE, 0, 0, 64, 32'h0f0f_f0f0));     // half side at the cap
    send_cmd(mk(MODE_SQUARE, 1, 1, 16'hffff, 32'hf0f0_0f0f)); // half side saturates
    send_cmd(mk(MODE_SQUARE, 3, 3, 3, 32'hdead_beef));      // odd side
    send_cmd(mk(MODE_DISC, 16'h8000, 16'h8000, 100, 32'h0));  // far off, most negative
    send_cmd(mk(MODE_DISC, 16'h7fff, 16'h7fff, 100, 32'h1));  // far off, most positive
    send_cmd(mk(MODE_DISC, -320, -240, 10, 32'h8000_0001));  // top-left corner clip
    send_cmd(mk(MODE_SQUARE, 319, 239, 20, 32'h7fff_fffe));  // bottom-right clip
    send_cmd(mk(MODE_DISC, -330, 0, 12, 32'h0102_0304));     // left edge clip
    send_cmd(mk(MODE_DISC, 330, 0, 12, 32'h0506_0708));      // right edge clip
    send_cmd(mk(MODE_DISC, 0, -250, 12, 32'h090a_0b0c));     // top edge clip
    send_cmd(mk(MODE_SQUARE, 0, 250, 30, 32'h0d0e_0f10));    // bottom edge clip
    send_cmd(mk(MODE_DISC, -340, 0, 5, 32'hcafe_f00d));      // rows on screen, no columns
    send_random(15);

    // shifted view, 2x zoom, small screen, swapped bytes; sender idles
    settle();
    apply_view(100, -50, 512, 320, 200, 1280, ORDER_HIGH_FIRST);
    send_idle_pct = 48;
    send_random(20);

    // extreme offsets, half zoom, largest legal screen and pitch; receiver stalls
    settle();
    apply_view(16'h8000, 16'h7fff, 128, 4096, 4096, 16384, ORDER_LOW_FIRST);
    send_idle_pct  = 0;
    recv_stall_pct = 48;
    send_random(20);

    // one-pixel screen, maximum zoom, smallest pitch; both sides idle a little
    settle();
    apply_view(0, 0, 16'hffff, 1, 1, 4, ORDER_HIGH_FIRST);
    send_idle_pct  = 11;
    recv_stall_pct = 11;
    send_random(12);

    // zero zoom and zero screen, nothing can show
    settle();
    apply_view(7, -9, 0, 0, 0, 4, ORDER_LOW_FIRST);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_random(8);

    // oversized screen and pitch, rows and addresses wrap in their fields
    settle();
    apply_view(0, 0, 256, 8191, 8191, 32767, ORDER_LOW_FIRST);
    recv_stall_pct = 48;
    send_random(20);

    // odd zoom near the reset view; both sides idle a little
    settle();
    apply_view(-3, 4, 300, 640, 480, 2560, ORDER_HIGH_FIRST);
    send_idle_pct  = 11;
    recv_stall_pct = 11;
    send_random(10);

    // drain, then give a stray span time to show up
    settle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
